// ===== rtl/windowed_sensor_capture_trigger_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed sensor capture trigger unit
// Shared property wrappers; the caller supplies clock and reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SENSOR_CAPTURE_TRIGGER_UNIT_ASSERT_SVH
`define WINDOWED_SENSOR_CAPTURE_TRIGGER_UNIT_ASSERT_SVH

// same-cycle implication
`define WSCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define WSCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== rtl/wsct_pkg.sv =====
// ----------------------------------------------------------------------------
// wsct_pkg
// Types and constants shared by the capture trigger unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsct_pkg;

   localparam int NUM_LANES   = 4;
   localparam int SUPPLY_LANE = 3;
   localparam int SAMPLE_W    = 16;
   localparam int TIME_W      = 32;
   localparam int CSR_DATA_W  = 34;
   localparam int CSR_INDEX_W = 3;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ARM  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_ACC_X  = 3'd0,
      CSR_WINDOW_ACC_Y  = 3'd1,
      CSR_WINDOW_ACC_Z  = 3'd2,
      CSR_WINDOW_SUPPLY = 3'd3,
      CSR_TIMEOUT       = 3'd4,
      CSR_COMBINE       = 3'd5,
      CSR_CAPTURE_TAG   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_TIMEOUT = 2'd1,
      CAUSE_SENSOR  = 2'd2
   } cause_type;

   typedef struct packed {
      logic                enable;
      logic                inside_mode;
      logic [SAMPLE_W-1:0] hi;
      logic [SAMPLE_W-1:0] lo;
   } window_type;

   typedef struct packed {
      logic require_all;
      logic fire_on_timeout;
   } combine_type;

   typedef struct packed {
      logic                erase;
      logic                camera;
      logic [SAMPLE_W-1:0] callback;
   } tag_type;

   typedef struct packed {
      logic                fired;
      cause_type           cause;
      logic                camera_sel;
      logic [SAMPLE_W-1:0] callback_tag;
      logic                erase_before;
      logic                still_waiting;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/wsct_window_lane.sv =====
// ----------------------------------------------------------------------------
// wsct_window_lane
// One sensor lane: half-open window test [lo,hi), inside or outside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsct_window_lane
   import wsct_pkg::*;
(
   input  window_type          win,
   input  logic                sign_mode,
   input  logic [SAMPLE_W-1:0] sample,
   output logic                hit
);

   logic signed [SAMPLE_W:0] rd;
   logic signed [SAMPLE_W:0] lo;
   logic signed [SAMPLE_W:0] hi;
   logic                     in_window;

   // one extra bit so signed and unsigned compares share the same comparator
   assign rd = {sign_mode & sample[SAMPLE_W-1], sample};
   assign lo = {sign_mode & win.lo[SAMPLE_W-1], win.lo};
   assign hi = {sign_mode & win.hi[SAMPLE_W-1], win.hi};

   assign in_window = (lo <= rd) && (rd < hi);
   assign hit       = win.enable && (win.inside_mode ? in_window : !in_window);

endmodule

`default_nettype wire

// ===== rtl/wsct_decide.sv =====
// ----------------------------------------------------------------------------
// wsct_decide
// Merges lane hits, checks the timeout and forms the result and next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsct_decide
   import wsct_pkg::*;
(
   input  logic                 cmd,
   input  logic [TIME_W-1:0]    now_ms,
   input  logic                 waiting,
   input  logic [TIME_W-1:0]    arm_time,
   input  logic [TIME_W-1:0]    timeout_limit,
   input  combine_type          combine,
   input  tag_type              tag,
   input  logic [NUM_LANES-1:0] lane_hit,
   output rsp_type              rsp,
   output logic                 next_waiting
);

   logic [TIME_W-1:0] elapsed;
   logic              timed_out;
   logic              sensor_hit;
   cause_type         cause;

   assign elapsed    = now_ms - arm_time;
   assign timed_out  = elapsed > timeout_limit;
   assign sensor_hit = combine.require_all ? (&lane_hit) : (|lane_hit);

   always_comb begin
      cause        = CAUSE_NONE;
      next_waiting = waiting;
      priority if (cmd == CMD_ARM) begin
         next_waiting = 1'b1;
      end else if (waiting && timed_out) begin
         next_waiting = 1'b0;
         if (combine.fire_on_timeout) begin
            cause = CAUSE_TIMEOUT;
         end
      end else if (waiting && sensor_hit) begin
         next_waiting = 1'b0;
         cause        = CAUSE_SENSOR;
      end
   end

   always_comb begin
      rsp               = '0;
      rsp.cause         = cause;
      rsp.fired         = (cause != CAUSE_NONE);
      rsp.still_waiting = next_waiting;
      if (cause != CAUSE_NONE) begin
         rsp.camera_sel   = tag.camera;
         rsp.callback_tag = tag.callback;
         rsp.erase_before = tag.erase;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/windowed_sensor_capture_trigger_unit.sv =====
// ----------------------------------------------------------------------------
// windowed_sensor_capture_trigger_unit
// Arm/tick capture trigger with four window lanes and a timeout.
// ----------------------------------------------------------------------------
// Takes one request beat per clock while req_ready is high and returns
// exactly one response beat per request, registered in the cycle after
// acceptance. Four lanes (x, y, z acceleration and supply) test their window
// in parallel and a merge stage combines them with the timeout check; the
// waiting flag and arm time are updated at acceptance, so back-to-back
// requests see each other's state. req_ready is high whenever the response
// register is empty or being drained in the same cycle; rsp_ready low while
// a response is held stalls the input in that cycle. Configuration writes
// take effect on the next clock; indexes above 6 are dropped.
`timescale 1ns / 1ps
`default_nettype none

module windowed_sensor_capture_trigger_unit
   import wsct_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic signed [SAMPLE_W-1:0] req_acc_x,
   input  logic signed [SAMPLE_W-1:0] req_acc_y,
   input  logic signed [SAMPLE_W-1:0] req_acc_z,
   input  logic [SAMPLE_W-1:0]    req_supply_raw,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_fired,
   output logic [1:0]             rsp_fire_cause,
   output logic                   rsp_camera_sel,
   output logic [SAMPLE_W-1:0]    rsp_callback_tag,
   output logic                   rsp_erase_before,
   output logic                   rsp_still_waiting
);

   window_type          window_ff [NUM_LANES];
   logic [TIME_W-1:0]   timeout_ff;
   combine_type         combine_ff;
   tag_type             tag_ff;

   logic                waiting_ff;
   logic [TIME_W-1:0]   arm_time_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [SAMPLE_W-1:0] lane_sample [NUM_LANES];
   logic [NUM_LANES-1:0] lane_hit;
   rsp_type             rsp_in;
   logic                waiting_in;
   logic                req_fire;

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            window_ff[i] <= '0;
         end
         timeout_ff <= '0;
         combine_ff <= '0;
         tag_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_ACC_X:  window_ff[0] <= csr_wdata;
            CSR_WINDOW_ACC_Y:  window_ff[1] <= csr_wdata;
            CSR_WINDOW_ACC_Z:  window_ff[2] <= csr_wdata;
            CSR_WINDOW_SUPPLY: window_ff[SUPPLY_LANE] <= csr_wdata;
            CSR_TIMEOUT:       timeout_ff <= csr_wdata[TIME_W-1:0];
            CSR_COMBINE:       combine_ff <= csr_wdata[$bits(combine_type)-1:0];
            CSR_CAPTURE_TAG:   tag_ff     <= csr_wdata[$bits(tag_type)-1:0];
            default: ;
         endcase
      end
   end

   // ---- sensor lanes ----
   assign lane_sample[0]           = req_acc_x;
   assign lane_sample[1]           = req_acc_y;
   assign lane_sample[2]           = req_acc_z;
   assign lane_sample[SUPPLY_LANE] = req_supply_raw;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      wsct_window_lane u_lane (
         .win       (window_ff[g]),
         .sign_mode (g != SUPPLY_LANE),
         .sample    (lane_sample[g]),
         .hit       (lane_hit[g])
      );
   end

   // ---- merge ----
   wsct_decide u_decide (
      .cmd           (req_cmd),
      .now_ms        (req_now_ms),
      .waiting       (waiting_ff),
      .arm_time      (arm_time_ff),
      .timeout_limit (timeout_ff),
      .combine       (combine_ff),
      .tag           (tag_ff),
      .lane_hit      (lane_hit),
      .rsp           (rsp_in),
      .next_waiting  (waiting_in)
   );

   // ---- handshake and state ----
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= 1'b0;
         arm_time_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            waiting_ff <= waiting_in;
            if (req_cmd == CMD_ARM) begin
               arm_time_ff <= req_now_ms;
            end
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_ff.fired;
   assign rsp_fire_cause    = rsp_ff.cause;
   assign rsp_camera_sel    = rsp_ff.camera_sel;
   assign rsp_callback_tag  = rsp_ff.callback_tag;
   assign rsp_erase_before  = rsp_ff.erase_before;
   assign rsp_still_waiting = rsp_ff.still_waiting;

endmodule

`default_nettype wire

// ===== rtl/wsct_checker.sv =====
// ----------------------------------------------------------------------------
// wsct_checker
// Port-level checks on the capture trigger unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_sensor_capture_trigger_unit_assert.svh"

module wsct_checker
   import wsct_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_cmd,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_fired,
   input logic [1:0]             rsp_fire_cause,
   input logic                   rsp_camera_sel,
   input logic [SAMPLE_W-1:0]    rsp_callback_tag,
   input logic                   rsp_erase_before,
   input logic                   rsp_still_waiting
);

   // fired flag and cause code agree; the unused code never shows
   `WSCT_ASSERT_IMPL(a_fired_cause, clock, reset, rsp_valid, (rsp_fired == (rsp_fire_cause != CAUSE_NONE)) && (rsp_fire_cause == CAUSE_NONE || rsp_fire_cause == CAUSE_TIMEOUT || rsp_fire_cause == CAUSE_SENSOR))

   // tag fields are zero on a beat that does not fire
   `WSCT_ASSERT_IMPL(a_quiet_tag, clock, reset, rsp_valid && !rsp_fired, !rsp_camera_sel && (rsp_callback_tag == '0) && !rsp_erase_before)

   // a firing always ends the waiting period
   `WSCT_ASSERT_IMPL(a_fire_ends_wait, clock, reset, rsp_valid && rsp_fired, !rsp_still_waiting)

   // an arm beat answers on the next cycle, waiting and not fired
   `WSCT_ASSERT_NEXT(a_arm_rsp, clock, reset, req_valid && req_ready && (req_cmd == CMD_ARM), rsp_valid && rsp_still_waiting && !rsp_fired)

endmodule

bind windowed_sensor_capture_trigger_unit wsct_checker u_wsct_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed sensor capture trigger unit. A
// scoreboard predicts one response per request beat from its own copy of the
// waiting flag, arm time and registers; random gaps and stalls on both
// channels, a long response hold and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import wsct_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 3'd7;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 60;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 75;

   // -------------------------------------------------------------------------
   class trigger_scoreboard;
      window_type  windows [NUM_LANES];
      logic [31:0] timeout_ms;
      combine_type combine;
      tag_type     tag;
      bit          armed;
      logic [31:0] armed_at;
      rsp_type     pending_rsp [$];
      int unsigned mismatches;

      function new();
         foreach (windows[i]) windows[i] = '0;
         timeout_ms = '0;
         combine    = '0;
         tag        = '0;
         armed      = 1'b0;
         armed_at   = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_WINDOW_ACC_X:  windows[0] = window_type'(data);
            CSR_WINDOW_ACC_Y:  windows[1] = window_type'(data);
            CSR_WINDOW_ACC_Z:  windows[2] = window_type'(data);
            CSR_WINDOW_SUPPLY: windows[SUPPLY_LANE] = window_type'(data);
            CSR_TIMEOUT:       timeout_ms = data[31:0];
            CSR_COMBINE:       combine = combine_type'(data[1:0]);
            CSR_CAPTURE_TAG:   tag = tag_type'(data[17:0]);
            default: ;
         endcase
      endfunction

      // half-open window [lo,hi); lo >= hi means inside never holds
      function bit lane_hit(window_type w, logic [15:0] sample, bit is_signed);
         logic signed [16:0] s, lo, hi;
         if (!w.enable) return 1'b0;
         s  = {is_signed & sample[15], sample};
         lo = {is_signed & w.lo[15], w.lo};
         hi = {is_signed & w.hi[15], w.hi};
         if (w.inside_mode) return (lo <= s) && (s < hi);
         return (s < lo) || (s >= hi);
      endfunction

      function void predict_trigger(logic cmd, logic [31:0] now, logic [15:0] ax,
                                    logic [15:0] ay, logic [15:0] az, logic [15:0] sup);
         logic [15:0] sample [NUM_LANES];
         logic [31:0] elapsed;
         cause_type   cause;
         rsp_type     r;
         bit          hit, any_hit, all_hit;
         sample[0] = ax;
         sample[1] = ay;
         sample[2] = az;
         sample[SUPPLY_LANE] = sup;
         cause = CAUSE_NONE;
         if (cmd == CMD_ARM) begin
            armed    = 1'b1;
            armed_at = now;
         end else if (armed) begin
            elapsed = now - armed_at;
            if (elapsed > timeout_ms) begin
               armed = 1'b0;
               if (combine.fire_on_timeout) cause = CAUSE_TIMEOUT;
            end else begin
               any_hit = 1'b0;
               all_hit = 1'b1;
               for (int lane = 0; lane < NUM_LANES; lane++) begin
                  hit = lane_hit(windows[lane], sample[lane], lane != SUPPLY_LANE);
                  any_hit |= hit;
                  all_hit &= hit;
               end
               if (combine.require_all ? all_hit : any_hit) cause = CAUSE_SENSOR;
            end
            if (cause != CAUSE_NONE) armed = 1'b0;
         end
         r = '0;
         r.fired = (cause != CAUSE_NONE);
         r.cause = cause;
         if (r.fired) begin
            r.camera_sel   = tag.camera;
            r.callback_tag = tag.callback;
            r.erase_before = tag.erase;
         end
         r.still_waiting = armed;
         pending_rsp.push_back(r);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_trigger(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
            return;
         end
         want = pending_rsp.pop_front();
         compare_field("fired", 16'(want.fired), 16'(got.fired));
         compare_field("fire_cause", 16'(want.cause), 16'(got.cause));
         compare_field("camera_sel", 16'(want.camera_sel), 16'(got.camera_sel));
         compare_field("callback_tag", want.callback_tag, got.callback_tag);
         compare_field("erase_before", 16'(want.erase_before), 16'(got.erase_before));
         compare_field("still_waiting", 16'(want.still_waiting), 16'(got.still_waiting));
      endfunction

      function bit clean();
         if (pending_rsp.size() != 0) begin
            $error("%0d responses never arrived", pending_rsp.size());
            mismatches++;
         end
         return mismatches == 0;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_wdata;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_cmd;
   logic [TIME_W-1:0]             req_now_ms;
   logic signed [SAMPLE_W-1:0]    req_acc_x;
   logic signed [SAMPLE_W-1:0]    req_acc_y;
   logic signed [SAMPLE_W-1:0]    req_acc_z;
   logic [SAMPLE_W-1:0]           req_supply_raw;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_fired;
   logic [1:0]                    rsp_fire_cause;
   logic                          rsp_camera_sel;
   logic [SAMPLE_W-1:0]           rsp_callback_tag;
   logic                          rsp_erase_before;
   logic                          rsp_still_waiting;

   trigger_scoreboard sb = new();

   window_type  cfg_win [NUM_LANES];
   logic [31:0] cfg_timeout;
   combine_type cfg_combine;
   tag_type     cfg_tag;
   bit          gaps_on;
   bit          stalls_on;
   bit          hold_pending;
   int unsigned idle_cycles = 0;

   always #5 clock = ~clock;

   windowed_sensor_capture_trigger_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_now_ms        (req_now_ms),
      .req_acc_x         (req_acc_x),
      .req_acc_y         (req_acc_y),
      .req_acc_z         (req_acc_z),
      .req_supply_raw    (req_supply_raw),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fired         (rsp_fired),
      .rsp_fire_cause    (rsp_fire_cause),
      .rsp_camera_sel    (rsp_camera_sel),
      .rsp_callback_tag  (rsp_callback_tag),
      .rsp_erase_before  (rsp_erase_before),
      .rsp_still_waiting (rsp_still_waiting)
   );

   // -------------------------------------------------------------------------
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic program_settings();
      write_reg(CSR_WINDOW_ACC_X, cfg_win[0]);
      write_reg(CSR_WINDOW_ACC_Y, cfg_win[1]);
      write_reg(CSR_WINDOW_ACC_Z, cfg_win[2]);
      write_reg(CSR_WINDOW_SUPPLY, cfg_win[SUPPLY_LANE]);
      write_reg(CSR_TIMEOUT, CSR_DATA_W'(cfg_timeout));
      write_reg(CSR_COMBINE, CSR_DATA_W'(cfg_combine));
      write_reg(CSR_CAPTURE_TAG, CSR_DATA_W'(cfg_tag));
      // index past the register file: must not disturb anything
      write_reg(CSR_INDEX_SPARE, '1);
      csr_we <= 1'b0;
   endtask

   task automatic send_request(logic cmd, logic [31:0] now, logic [15:0] ax,
                               logic [15:0] ay, logic [15:0] az, logic [15:0] sup);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_now_ms     <= now;
      req_acc_x      <= ax;
      req_acc_y      <= ay;
      req_acc_z      <= az;
      req_supply_raw <= sup;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_trigger(cmd, now, ax, ay, az, sup);
   endtask

   // sender stops and waits until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic window_type random_window();
      window_type  w;
      logic [15:0] mid, span;
      w.enable = $urandom_range(0, 4) != 0;
      w.inside_mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: begin
            w.lo = 16'($urandom);
            w.hi = 16'($urandom);
         end
         1: begin
            mid  = 16'($urandom);
            span = 16'($urandom_range(1, 3000));
            w.lo = mid - span;
            w.hi = mid + span;
         end
         2: begin
            // widest window, signed or unsigned reading
            w.lo = $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
            w.hi = (w.lo == 16'h8000) ? 16'h7FFF : 16'hFFFF;
         end
         default: begin
            w.lo = 16'($urandom);
            w.hi = w.lo;
         end
      endcase
      return w;
   endfunction

   // half the samples on or next to a window edge, the rest at extremes or random
   function automatic logic [15:0] pick_sample(window_type w);
      case ($urandom_range(0, 7))
         0: return w.lo;
         1: return w.lo - 16'd1;
         2: return w.hi;
         3: return w.hi - 16'd1;
         4: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         5: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // response side
   initial begin
      int unsigned stall;
      rsp_type     got;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = stalls_on ? $urandom_range(0, 8) : 0;
         if (hold_pending) begin
            stall        = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         got.fired         = rsp_fired;
         got.cause         = cause_type'(rsp_fire_cause);
         got.camera_sel    = rsp_camera_sel;
         got.callback_tag  = rsp_callback_tag;
         got.erase_before  = rsp_erase_before;
         got.still_waiting = rsp_still_waiting;
         sb.check_trigger(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   initial begin
      int unsigned sent;
      logic [31:0] cur_time;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_TICK;
      req_now_ms     <= '0;
      req_acc_x      <= '0;
      req_acc_y      <= '0;
      req_acc_z      <= '0;
      req_supply_raw <= '0;
      gaps_on        = 1'b0;
      stalls_on      = 1'b0;
      hold_pending   = 1'b0;
      cur_time       = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // x inside [-100,100), y off, z outside the widest window,
      // supply inside an inverted window, OR, fire on timeout
      cfg_win[0] = '{1'b1, 1'b1, 16'd100, 16'hFF9C};
      cfg_win[1] = '{1'b0, 1'b1, 16'h7FFF, 16'h8000};
      cfg_win[2] = '{1'b0 | 1'b1, 1'b0, 16'h7FFF, 16'h8000};
      cfg_win[SUPPLY_LANE] = '{1'b1, 1'b1, 16'd100, 16'd500};
      cfg_timeout = 32'd1000;
      cfg_combine = '{require_all: 1'b0, fire_on_timeout: 1'b1};
      cfg_tag     = 18'h3FFFF;
      program_settings();
      stalls_on = 1'b1;
      gaps_on   = 1'b1;
      send_request(CMD_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_ARM, 32'hFFFF_FF00, 16'd0, 16'd0, 16'd0, 16'd0);
      // elapsed wraps through zero
      send_request(CMD_TICK, 32'h0000_0100, 16'd500, 16'h8000, 16'd0, 16'hFFFF);
      send_request(CMD_TICK, 32'h0000_0100, 16'd500, 16'd0, 16'h7FFF, 16'd0);
      send_request(CMD_TICK, 32'h0000_0101, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_ARM, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(CMD_ARM, 32'd50, 16'd0, 16'd0, 16'd0, 16'd0);
      // elapsed equal to the limit still checks the windows
      send_request(CMD_TICK, 32'd1050, -16'sd101, 16'd0, 16'd0, 16'd300);
      send_request(CMD_TICK, 32'd1051, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_ARM, 32'd2000, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_TICK, 32'd2000, -16'sd100, 16'd0, 16'd0, 16'd0);
      send_request(CMD_ARM, 32'd3000, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_TICK, 32'd3999, 16'd100, 16'd0, 16'd0, 16'd0);
      send_request(CMD_TICK, 32'd4000, 16'd99, 16'd0, 16'd0, 16'd0);
      drain();

      // AND of all four lanes, y outside an empty window, no timeout
      cfg_win[0] = '{1'b1, 1'b1, 16'h7FFF, 16'h8000};
      cfg_win[1] = '{1'b1, 1'b0, 16'd0, 16'd0};
      cfg_win[2] = '{1'b1, 1'b1, 16'd5, 16'hFFFB};
      cfg_win[SUPPLY_LANE] = '{1'b1, 1'b1, 16'hFFFF, 16'd0};
      cfg_timeout = 32'hFFFF_FFFF;
      cfg_combine = '{require_all: 1'b1, fire_on_timeout: 1'b0};
      cfg_tag     = 18'h1_0001;
      program_settings();
      send_request(CMD_ARM, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_TICK, 32'hFFFF_FFFE, 16'h8000, 16'd5, 16'd0, 16'd0);
      send_request(CMD_ARM, 32'd100, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_TICK, 32'd100, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_request(CMD_TICK, 32'd100, 16'h7FFF, 16'd0, 16'd0, 16'd10);
      send_request(CMD_TICK, 32'd100, 16'h7FFE, 16'hFFFF, 16'd4, 16'hFFFE);
      drain();

      // AND with three lanes off can never fire; zero timeout, silent
      cfg_win[1] = '{1'b0, 1'b1, 16'h7FFF, 16'h8000};
      cfg_win[2] = '{1'b0, 1'b1, 16'h7FFF, 16'h8000};
      cfg_win[SUPPLY_LANE] = '{1'b0, 1'b1, 16'hFFFF, 16'd0};
      cfg_timeout = 32'd0;
      cfg_tag     = 18'h2_0000;
      program_settings();
      send_request(CMD_ARM, 32'd7, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_TICK, 32'd7, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(CMD_TICK, 32'd8, 16'd0, 16'd0, 16'd0, 16'd0);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         foreach (cfg_win[i]) cfg_win[i] = random_window();
         case ($urandom_range(0, 4))
            0: cfg_timeout = 32'd0;
            1: cfg_timeout = 32'hFFFF_FFFF;
            4: cfg_timeout = $urandom;
            default: cfg_timeout = $urandom_range(1, 400);
         endcase
         cfg_combine = combine_type'($urandom_range(0, 3));
         cfg_tag     = tag_type'(18'($urandom));
         program_settings();
         // first phase runs without any idling on either side
         gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
         stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         if (ph == 2) hold_pending = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
               if ($urandom_range(0, 7) == 0)
                  cur_time = 32'hFFFF_FFFF - $urandom_range(0, 300);
               else
                  cur_time = cur_time + $urandom_range(0, 5000);
               send_request(CMD_ARM, cur_time, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
               sent++;
               repeat ($urandom_range(1, 8)) begin
                  cur_time = cur_time + $urandom_range(0, 120);
                  send_request(CMD_TICK, cur_time, pick_sample(cfg_win[0]),
                               pick_sample(cfg_win[1]), pick_sample(cfg_win[2]),
                               pick_sample(cfg_win[SUPPLY_LANE]));
                  sent++;
               end
            end else begin
               send_request(1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
               sent++;
            end
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (sb.clean()) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
